FILE: sv/rrb_pkg.sv
// Shared definitions for the relay register block: opcodes, register map addresses,
// configuration indexes and reset values, port field widths and the access decode struct.
// Has no dependencies; every other file of the block imports it.
`default_nettype none

package rrb_pkg;

    // Field widths of the stream words.
    localparam int OP_W      = 2;
    localparam int ADDR_W    = 16;
    localparam int VALUE_W   = 16;
    localparam int RDATA_W   = 16;
    localparam int RELAY_W   = 8;
    localparam int CNT_W     = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int IN_DATA_W = 32;
    localparam int OUT_DATA_W = 32;

    // Default number of relays behind the block.
    localparam int RRB_RELAY_BITS = 8;

    // Item kinds carried in the slave tuser.
    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2
    } t_opcode;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LOSS_TIMEOUT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_APPLY_PERIOD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SUPV_PERIOD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOT_DELAY   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SERVICE_KEY  = 3'd4;

    // Configuration reset values.
    localparam logic [CFG_W-1:0] RST_LOSS_TIMEOUT = 16'd10000;
    localparam logic [CFG_W-1:0] RST_APPLY_PERIOD = 16'd100;
    localparam logic [CFG_W-1:0] RST_SUPV_PERIOD  = 16'd500;
    localparam logic [CFG_W-1:0] RST_BOOT_DELAY   = 16'd50;
    localparam logic [CFG_W-1:0] RST_SERVICE_KEY  = 16'd20118;

    // Holding register map.
    localparam logic [ADDR_W-1:0] ADDR_RELAY    = 16'd0;
    localparam logic [ADDR_W-1:0] ADDR_RELAY_RB = 16'd1;
    localparam logic [ADDR_W-1:0] ADDR_ZERO     = 16'd3;
    localparam logic [ADDR_W-1:0] ADDR_SERVICE  = 16'd580;
    localparam logic [ADDR_W-1:0] ADDR_RSV0     = 16'd590;
    localparam logic [ADDR_W-1:0] ADDR_RSV1     = 16'd591;
    localparam logic [ADDR_W-1:0] ADDR_RSV2     = 16'd592;
    localparam logic [ADDR_W-1:0] ADDR_RSV3     = 16'd593;
    localparam logic [ADDR_W-1:0] ADDR_REBOOT   = 16'd594;
    localparam logic [ADDR_W-1:0] ADDR_BOOT     = 16'd900;

    localparam logic [RDATA_W-1:0] RDATA_UNKNOWN = 16'hFFFF;

    // Outcome of one register access, from the decoder to the state update.
    typedef struct packed {
        logic [RDATA_W-1:0] read_data;
        logic               wr_relay;
        logic               set_service;
        logic               set_reboot;
        logic               set_boot;
    } t_acc;

endpackage

`default_nettype wire

FILE: sv/rrb_regmap.sv
// Holding register decoder: turns one read or write access into read data and write strobes.
// Depends on rrb_pkg for the address map and the t_acc struct.
`default_nettype none

module rrb_regmap
    import rrb_pkg::*;
(
    input  wire logic               i_wr,
    input  wire logic [ADDR_W-1:0]  i_addr,
    input  wire logic [VALUE_W-1:0] i_value,
    input  wire logic [CFG_W-1:0]   i_service_key,
    input  wire logic [RELAY_W-1:0] i_applied,
    input  wire logic               i_service,
    input  wire logic               i_reboot,
    input  wire logic               i_boot_pending,
    output t_acc                    o_acc
);

    logic w_key_ok;

    assign w_key_ok = i_wr && (i_value == i_service_key);

    always_comb begin
        o_acc = '0;
        unique case (i_addr) inside
            ADDR_RELAY: begin
                // A write to the relay register answers zero; a read gives the applied pattern.
                o_acc.wr_relay  = i_wr;
                o_acc.read_data = i_wr ? '0 : RDATA_W'(i_applied);
            end
            ADDR_RELAY_RB: o_acc.read_data = RDATA_W'(i_applied);
            ADDR_ZERO, ADDR_RSV0, ADDR_RSV1, ADDR_RSV2, ADDR_RSV3: o_acc.read_data = '0;
            ADDR_SERVICE: begin
                o_acc.set_service = w_key_ok;
                o_acc.read_data   = RDATA_W'(i_service || w_key_ok);
            end
            ADDR_REBOOT: begin
                o_acc.set_reboot = i_wr;
                o_acc.read_data  = RDATA_W'(i_reboot || i_wr);
            end
            ADDR_BOOT: begin
                o_acc.set_boot  = i_wr;
                o_acc.read_data = RDATA_W'(i_boot_pending || i_wr);
            end
            default: o_acc.read_data = RDATA_UNKNOWN;
        endcase
    end

endmodule

`default_nettype wire

FILE: sv/relay_register_block_link_timeout_core.sv
// Top level of the relay register block: stream ports, configuration registers, state and timers.
// Depends on rrb_pkg and instantiates rrb_regmap.
`default_nettype none

// Relay output controller behind a small holding-register map. Every slave word is one item:
// a one-millisecond tick (tuser = tick), a register read or a register write, and every item
// yields exactly one master word carrying the read data and a snapshot of the relay, link, LED,
// service, reboot and boot-jump state after that item. Writes to register 0 set the commanded
// relay pattern; on ticks the apply task copies it to the relay outputs once per apply period
// and services a pending reboot (which freezes the block for good) or a delayed boot jump, and
// the supervise task drops the link, clears the commanded pattern and blinks the LED once no
// access has arrived for the loss timeout. The block takes one word per clock as long as the
// master side takes its words: a word is captured in an input register, its whole effect is
// computed in one pass of short logic (a few 16-bit saturating increments and compares plus
// the address decode) and lands in an output register. Configuration is written through
// i_cfg_we/i_cfg_addr/i_cfg_data; the user must write it only while no word is in flight, as
// the block does not enforce this. Indexes beyond the register list are ignored.

module relay_register_block_link_timeout_core
    import rrb_pkg::*;
#(
    parameter int RELAY_BITS = RRB_RELAY_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // tdata fields from bit 0 up: reg_addr[15:0], write_value[31:16].
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // tuser fields from bit 0 up: opcode[1:0].
    input  wire logic [OP_W-1:0]       s_axis_tuser,

    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // tdata fields from bit 0 up: read_data[15:0], relay_outputs[23:16], link_ok[24],
    // status_led[25], service_active[26], reboot_now[27], boot_jump[28], zeros[31:29].
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,

    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  wire logic [CFG_W-1:0]      i_cfg_data
);

    // Relay storage is as wide as the relays, capped by the 8-bit field of the result.
    localparam int RLY_W = (RELAY_BITS < RELAY_W) ? RELAY_BITS : RELAY_W;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + CNT_W'(1);
    endfunction

    // Configuration registers.
    logic [CFG_W-1:0] r_loss_timeout, r_apply_period, r_supv_period, r_boot_delay, r_service_key;

    // Input stage.
    logic               r_in_valid;
    logic [OP_W-1:0]    r_in_op;
    logic [ADDR_W-1:0]  r_in_addr;
    logic [VALUE_W-1:0] r_in_value;

    // Block state and its next values.
    logic [RLY_W-1:0] r_applied, n_applied, r_commanded, n_commanded;
    logic             r_service, n_service, r_reboot, n_reboot, r_boot_pending, n_boot_pending;
    logic             r_link, n_link, r_led, n_led, r_frozen, n_frozen;
    logic [CNT_W-1:0] r_boot_elapsed, n_boot_elapsed, r_idle_elapsed, n_idle_elapsed;
    logic [CNT_W-1:0] r_apply_elapsed, n_apply_elapsed, r_supv_elapsed, n_supv_elapsed;
    logic             n_jump;
    logic [RDATA_W-1:0] n_rdata;

    // Output stage.
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [OUT_DATA_W-1:0] n_out_data;

    logic             w_adv;
    logic [CNT_W-1:0] w_apply_inc, w_supv_inc, w_idle_inc, w_boot_inc;
    logic             w_apply_fire, w_supv_fire;
    t_acc             w_acc;

    // The pass advances when a word waits and the output register is free or being emptied.
    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    rrb_regmap u_regmap (
        .i_wr           (r_in_op == OP_WRITE),
        .i_addr         (r_in_addr),
        .i_value        (r_in_value),
        .i_service_key  (r_service_key),
        .i_applied      (RELAY_W'(r_applied)),
        .i_service      (r_service),
        .i_reboot       (r_reboot),
        .i_boot_pending (r_boot_pending),
        .o_acc          (w_acc)
    );

    // Tick counters advance first, saturating; the boot counter only runs while a jump waits.
    assign w_apply_inc  = sat_inc(r_apply_elapsed);
    assign w_supv_inc   = sat_inc(r_supv_elapsed);
    assign w_idle_inc   = sat_inc(r_idle_elapsed);
    assign w_boot_inc   = r_boot_pending ? sat_inc(r_boot_elapsed) : r_boot_elapsed;
    assign w_apply_fire = (w_apply_inc >= r_apply_period);
    // A reboot serviced by the apply task ends the tick before supervision runs.
    assign w_supv_fire  = (w_supv_inc >= r_supv_period) && !(w_apply_fire && r_reboot);

    always_comb begin
        n_applied       = r_applied;
        n_commanded     = r_commanded;
        n_service       = r_service;
        n_reboot        = r_reboot;
        n_boot_pending  = r_boot_pending;
        n_boot_elapsed  = r_boot_elapsed;
        n_link          = r_link;
        n_led           = r_led;
        n_frozen        = r_frozen;
        n_idle_elapsed  = r_idle_elapsed;
        n_apply_elapsed = r_apply_elapsed;
        n_supv_elapsed  = r_supv_elapsed;
        n_jump          = 1'b0;
        n_rdata         = '0;

        if (!r_frozen) begin
            case (r_in_op)
                OP_TICK: begin
                    n_apply_elapsed = w_apply_inc;
                    n_supv_elapsed  = w_supv_inc;
                    n_idle_elapsed  = w_idle_inc;
                    n_boot_elapsed  = w_boot_inc;
                    if (w_apply_fire) begin
                        n_apply_elapsed = '0;
                        n_applied       = r_commanded;
                        if (r_reboot) begin
                            n_frozen = 1'b1;
                        end else if (r_boot_pending && (w_boot_inc > r_boot_delay)) begin
                            n_boot_pending = 1'b0;
                            n_jump         = 1'b1;
                        end
                    end
                    if (w_supv_fire) begin
                        n_supv_elapsed = '0;
                        if (w_idle_inc >= r_loss_timeout) begin
                            n_link      = 1'b0;
                            n_commanded = '0;
                        end
                        // The LED blinks only while the link is down after this check.
                        if (!n_link) begin
                            n_led = !r_led;
                        end
                    end
                end
                OP_READ, OP_WRITE: begin
                    n_idle_elapsed = '0;
                    if (!r_link) begin
                        n_link = 1'b1;
                        n_led  = 1'b1;
                    end
                    n_rdata = w_acc.read_data;
                    if (w_acc.wr_relay) begin
                        n_commanded = r_in_value[RLY_W-1:0];
                    end
                    if (w_acc.set_service) begin
                        n_service = 1'b1;
                    end
                    if (w_acc.set_reboot) begin
                        n_reboot = 1'b1;
                    end
                    if (w_acc.set_boot) begin
                        n_boot_pending = 1'b1;
                        n_boot_elapsed = '0;
                    end
                end
                default: ;
            endcase
        end

        n_out_data = {3'b000, n_jump, n_frozen, n_service, n_led, n_link,
                      RELAY_W'(n_applied), n_rdata};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loss_timeout  <= RST_LOSS_TIMEOUT;
            r_apply_period  <= RST_APPLY_PERIOD;
            r_supv_period   <= RST_SUPV_PERIOD;
            r_boot_delay    <= RST_BOOT_DELAY;
            r_service_key   <= RST_SERVICE_KEY;
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_applied       <= '0;
            r_commanded     <= '0;
            r_service       <= 1'b0;
            r_reboot        <= 1'b0;
            r_boot_pending  <= 1'b0;
            r_boot_elapsed  <= '0;
            r_link          <= 1'b0;
            r_led           <= 1'b0;
            r_frozen        <= 1'b0;
            r_idle_elapsed  <= '0;
            r_apply_elapsed <= '0;
            r_supv_elapsed  <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_LOSS_TIMEOUT: r_loss_timeout <= i_cfg_data;
                    CFG_APPLY_PERIOD: r_apply_period <= i_cfg_data;
                    CFG_SUPV_PERIOD:  r_supv_period  <= i_cfg_data;
                    CFG_BOOT_DELAY:   r_boot_delay   <= i_cfg_data;
                    CFG_SERVICE_KEY:  r_service_key  <= i_cfg_data;
                    default: ;
                endcase
            end

            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end

            if (w_adv) begin
                r_out_valid     <= 1'b1;
                r_applied       <= n_applied;
                r_commanded     <= n_commanded;
                r_service       <= n_service;
                r_reboot        <= n_reboot;
                r_boot_pending  <= n_boot_pending;
                r_boot_elapsed  <= n_boot_elapsed;
                r_link          <= n_link;
                r_led           <= n_led;
                r_frozen        <= n_frozen;
                r_idle_elapsed  <= n_idle_elapsed;
                r_apply_elapsed <= n_apply_elapsed;
                r_supv_elapsed  <= n_supv_elapsed;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers load without reset.
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_op    <= s_axis_tuser;
            r_in_addr  <= s_axis_tdata[ADDR_W-1:0];
            r_in_value <= s_axis_tdata[ADDR_W +: VALUE_W];
        end
        if (w_adv) begin
            r_out_data <= n_out_data;
        end
    end

    // Once frozen, the block never thaws.
    a_frozen_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frozen |=> r_frozen)
        else $error("frozen flag cleared");

    // A frozen block leaves the relay outputs untouched.
    a_frozen_relays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_frozen && w_adv) |=> $stable(r_applied))
        else $error("relay outputs changed while frozen");

    // With the link up the LED is steadily on.
    a_link_led: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_link |-> r_led)
        else $error("link up with LED off");

    // A boot jump pulse never comes with a reboot freeze in the same word.
    a_jump_not_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_data[28] |-> !r_out_data[27])
        else $error("boot jump reported together with reboot");

endmodule

`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for relay_register_block_link_timeout_core: drives tick, read, write and
// unused-opcode words, predicts every status word with a cycle-free model of the relay controller
// and checks them in order. Depends on rrb_pkg and the block's RTL only.

module testbench;
    import rrb_pkg::*;

    // Opcode value that the block must ignore; the package enum leaves it out.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // Cycles without any accepted word before the run is declared hung. The slowest legal gap
    // is the receiver's long hold-off plus idle stretches on each side and the register writes
    // between phases.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_AT        = 400;
    localparam int HOLD_LEN       = 150;

    // One input word as the testbench sees it.
    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [ADDR_W-1:0]  addr;
        logic [VALUE_W-1:0] value;
    } t_relay_item;

    // One status word, field by field.
    typedef struct packed {
        logic [RDATA_W-1:0] rdata;
        logic [RELAY_W-1:0] relays;
        logic               link;
        logic               led;
        logic               service;
        logic               reboot;
        logic               jump;
    } t_status_word;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [OP_W-1:0]       s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_addr    = '0;
    logic [CFG_W-1:0]      i_cfg_data    = '0;

    relay_register_block_link_timeout_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Words waiting to be offered, and status words predicted but not yet seen.
    t_relay_item  pending_items[$];
    t_status_word status_expected[$];
    t_relay_item  on_bus;
    t_status_word want;

    int send_idle_pct = 17;
    int recv_idle_pct = 68;
    int hold_left     = 0;
    bit hold_done     = 1'b0;
    int idle_cycles   = 0;

    int items_sent     = 0;
    int words_checked  = 0;
    int fail_count     = 0;
    int settings_used  = 0;
    int losses_seen    = 0;
    int jumps_seen     = 0;

    // Predictor copy of the configuration registers, at their reset values.
    logic [CFG_W-1:0] cfg_loss       = RST_LOSS_TIMEOUT;
    logic [CFG_W-1:0] cfg_apply      = RST_APPLY_PERIOD;
    logic [CFG_W-1:0] cfg_supv       = RST_SUPV_PERIOD;
    logic [CFG_W-1:0] cfg_boot_delay = RST_BOOT_DELAY;
    logic [CFG_W-1:0] cfg_key        = RST_SERVICE_KEY;

    // Predictor copy of the block state; all of it clears on reset.
    logic [RELAY_W-1:0] relay_applied = '0;
    logic [RELAY_W-1:0] relay_cmd     = '0;
    logic               svc_flag      = 1'b0;
    logic               reboot_req    = 1'b0;
    logic               boot_armed    = 1'b0;
    logic               link_up       = 1'b0;
    logic               led_on        = 1'b0;
    logic               frozen_q      = 1'b0;
    logic [CNT_W-1:0]   boot_ticks    = '0;
    logic [CNT_W-1:0]   idle_ticks    = '0;
    logic [CNT_W-1:0]   apply_ticks   = '0;
    logic [CNT_W-1:0]   supv_ticks    = '0;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // Advances the predicted state by one accepted word and returns the status word it causes.
    function automatic t_status_word next_status_word(input t_relay_item it);
        t_status_word w;
        logic [RDATA_W-1:0] rd;
        logic jump;
        logic stop;
        logic wr;
        rd   = '0;
        jump = 1'b0;
        stop = 1'b0;
        wr   = (it.op == OP_WRITE);
        if (!frozen_q) begin
            if (it.op == OP_TICK) begin
                // Counters first, then the apply task, then the supervise task.
                apply_ticks = sat_inc(apply_ticks);
                supv_ticks  = sat_inc(supv_ticks);
                idle_ticks  = sat_inc(idle_ticks);
                if (boot_armed)
                    boot_ticks = sat_inc(boot_ticks);
                if (apply_ticks >= cfg_apply) begin
                    apply_ticks   = '0;
                    relay_applied = relay_cmd;
                    if (reboot_req) begin
                        // A pending reboot wins over the boot jump and stops everything else.
                        frozen_q = 1'b1;
                        stop     = 1'b1;
                    end else if (boot_armed && boot_ticks > cfg_boot_delay) begin
                        boot_armed = 1'b0;
                        jump       = 1'b1;
                        jumps_seen++;
                    end
                end
                if (!stop && supv_ticks >= cfg_supv) begin
                    supv_ticks = '0;
                    if (idle_ticks >= cfg_loss) begin
                        if (link_up)
                            losses_seen++;
                        link_up   = 1'b0;
                        relay_cmd = '0;
                    end
                    if (!link_up)
                        led_on = ~led_on;
                end
            end else if (it.op == OP_READ || wr) begin
                // Any access restores the link and lights the LED.
                idle_ticks = '0;
                if (!link_up) begin
                    link_up = 1'b1;
                    led_on  = 1'b1;
                end
                case (it.addr)
                    ADDR_RELAY: begin
                        if (wr)
                            relay_cmd = it.value[RELAY_W-1:0];
                        else
                            rd = {{(RDATA_W-RELAY_W){1'b0}}, relay_applied};
                    end
                    ADDR_RELAY_RB: rd = {{(RDATA_W-RELAY_W){1'b0}}, relay_applied};
                    ADDR_ZERO, ADDR_RSV0, ADDR_RSV1, ADDR_RSV2, ADDR_RSV3: rd = '0;
                    ADDR_SERVICE: begin
                        if (wr && it.value == cfg_key)
                            svc_flag = 1'b1;
                        rd = {{(RDATA_W-1){1'b0}}, svc_flag};
                    end
                    ADDR_REBOOT: begin
                        if (wr)
                            reboot_req = 1'b1;
                        rd = {{(RDATA_W-1){1'b0}}, reboot_req};
                    end
                    ADDR_BOOT: begin
                        if (wr) begin
                            boot_armed = 1'b1;
                            boot_ticks = '0;
                        end
                        rd = {{(RDATA_W-1){1'b0}}, boot_armed};
                    end
                    default: rd = RDATA_UNKNOWN;
                endcase
            end
        end
        w.rdata   = rd;
        w.relays  = relay_applied;
        w.link    = link_up;
        w.led     = led_on;
        w.service = svc_flag;
        w.reboot  = frozen_q;
        w.jump    = jump;
        return w;
    endfunction

    function automatic void check_field(input string name, input int unsigned want_v,
                                        input int unsigned got_v);
        if (want_v != got_v) begin
            fail_count++;
            $error("%s mismatch: expected %0h, got %0h", name, want_v, got_v);
        end
    endfunction

    // Driver. The word on the bus is predicted at the edge that accepts it; the next pending
    // word, if the sender is not idling this cycle, is put up at the same edge. Valid only
    // changes when the slot is free, so a held word is never withdrawn.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                status_expected.push_back(next_status_word(on_bus));
                items_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    on_bus = pending_items.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= on_bus.op;
                    s_axis_tdata  <= {on_bus.value, on_bus.addr};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor. Every accepted status word is checked against the oldest prediction. Once, after
    // HOLD_AT words, the receiver holds ready low for a hold-off set by HOLD_LEN so the block
    // backs up and stalls its slave side while the driver keeps offering.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (status_expected.size() == 0) begin
                    fail_count++;
                    $error("status word %h arrived with nothing expected", m_axis_tdata);
                end else begin
                    want = status_expected.pop_front();
                    // Field layout from bit 0: read_data, relay_outputs, link_ok, status_led,
                    // service_active, reboot_now, boot_jump.
                    check_field("read_data",      want.rdata,   m_axis_tdata[15:0]);
                    check_field("relay_outputs",  want.relays,  m_axis_tdata[23:16]);
                    check_field("link_ok",        want.link,    m_axis_tdata[24]);
                    check_field("status_led",     want.led,     m_axis_tdata[25]);
                    check_field("service_active", want.service, m_axis_tdata[26]);
                    check_field("reboot_now",     want.reboot,  m_axis_tdata[27]);
                    check_field("boot_jump",      want.jump,    m_axis_tdata[28]);
                    words_checked++;
                end
            end
            if (hold_left != 0) begin
                hold_left     <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end else if (!hold_done && words_checked >= HOLD_AT) begin
                hold_done     <= 1'b1;
                hold_left     <= HOLD_LEN;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog: ends the run when no word moves on either side for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == WATCHDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic push_item(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                             input logic [VALUE_W-1:0] value);
        t_relay_item it;
        it.op    = op;
        it.addr  = addr;
        it.value = value;
        pending_items.push_back(it);
    endtask

    task automatic push_ticks(input int n);
        repeat (n) push_item(OP_TICK, ADDR_W'($urandom), VALUE_W'($urandom));
    endtask

    // Sender pause: nothing queued, nothing on the bus and every predicted word received,
    // then a further wait for the two-stage pipeline to settle.
    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (pending_items.size() != 0 || s_axis_tvalid || status_expected.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic program_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_LOSS_TIMEOUT: cfg_loss       = val;
            CFG_APPLY_PERIOD: cfg_apply      = val;
            CFG_SUPV_PERIOD:  cfg_supv       = val;
            CFG_BOOT_DELAY:   cfg_boot_delay = val;
            CFG_SERVICE_KEY:  cfg_key        = val;
            default: ;
        endcase
    endtask

    // Starts a phase: drain the block, pick the idling mix, then write all five registers.
    task automatic start_phase(input logic [CFG_W-1:0] loss, input logic [CFG_W-1:0] apply,
                               input logic [CFG_W-1:0] supv, input logic [CFG_W-1:0] bdelay,
                               input logic [CFG_W-1:0] key, input int sidle, input int ridle);
        wait_drained();
        send_idle_pct = sidle;
        recv_idle_pct = ridle;
        program_reg(CFG_LOSS_TIMEOUT, loss);
        program_reg(CFG_APPLY_PERIOD, apply);
        program_reg(CFG_SUPV_PERIOD,  supv);
        program_reg(CFG_BOOT_DELAY,   bdelay);
        program_reg(CFG_SERVICE_KEY,  key);
        settings_used++;
    endtask

    // Addresses weighted toward the decoded map and its immediate neighbors.
    function automatic logic [ADDR_W-1:0] pick_addr();
        case ($urandom_range(15))
            0, 1, 2: return ADDR_RELAY;
            3:       return ADDR_RELAY_RB;
            4:       return ADDR_ZERO;
            5:       return ADDR_SERVICE;
            6:       return ADDR_RSV0 + ADDR_W'($urandom_range(3));
            7:       return ADDR_REBOOT;
            8:       return ADDR_BOOT;
            9: begin
                case ($urandom_range(6))
                    0: return ADDR_ZERO - 1'b1;
                    1: return ADDR_SERVICE - 1'b1;
                    2: return ADDR_SERVICE + 1'b1;
                    3: return ADDR_RSV0 - 1'b1;
                    4: return ADDR_REBOOT + 1'b1;
                    5: return ADDR_BOOT - 1'b1;
                    default: return ADDR_BOOT + 1'b1;
                endcase
            end
            default: return ADDR_W'($urandom);
        endcase
    endfunction

    // Random traffic shaped like a live link: runs of ticks long enough to cross a short loss
    // timeout, register accesses, boot-jump requests followed by enough ticks to fire when the
    // delay is short, and some noise. A write to the reboot register is never generated here,
    // since it would freeze the block for the rest of the run.
    task automatic add_random(input int n);
        int added;
        int kind;
        int len;
        int len_max;
        logic [OP_W-1:0]    op;
        logic [ADDR_W-1:0]  a;
        logic [VALUE_W-1:0] v;
        added = 0;
        while (added < n) begin
            kind = int'($urandom_range(99));
            if (kind < 40) begin
                len_max = (cfg_loss > 38) ? 120 : 3 * cfg_loss + 4;
                len = (kind < 8) ? int'($urandom_range(len_max, 1)) : int'($urandom_range(12, 1));
                push_ticks(len);
                added += len;
            end else if (kind < 80) begin
                op = $urandom_range(1) ? OP_WRITE : OP_READ;
                a  = pick_addr();
                v  = VALUE_W'($urandom);
                if (a == ADDR_SERVICE && $urandom_range(3) == 0)
                    v = cfg_key;
                if (op == OP_WRITE && a == ADDR_REBOOT)
                    op = OP_READ;
                push_item(op, a, v);
                added++;
            end else if (kind < 87) begin
                push_item(OP_WRITE, ADDR_BOOT, VALUE_W'($urandom));
                len = cfg_boot_delay + cfg_apply + 2;
                if (len > 150)
                    len = 150;
                push_ticks(len);
                added += len + 1;
            end else if (kind < 94) begin
                // Ignored by the block, so it does not count toward the phase size.
                push_item(OP_UNUSED, ADDR_W'($urandom), VALUE_W'($urandom));
            end else begin
                op = OP_W'($urandom_range(3));
                a  = ADDR_W'($urandom);
                if (op == OP_WRITE && a == ADDR_REBOOT)
                    a = ADDR_REBOOT + 1'b1;
                push_item(op, a, VALUE_W'($urandom));
                if (op != OP_UNUSED)
                    added++;
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words at reset configuration: every decoded address but ADDR_RSV2, unknown
        // addresses at the edges of the range, write values at their extremes, ignored writes,
        // the unused opcode and plain ticks.
        settings_used = 1;
        push_item(OP_READ,  ADDR_RELAY,    16'h0000);
        push_item(OP_READ,  ADDR_RELAY_RB, 16'hFFFF);
        push_item(OP_READ,  ADDR_ZERO,     16'h0000);
        push_item(OP_READ,  16'hFFFF,      16'hFFFF);
        push_item(OP_READ,  16'h0002,      16'h0000);
        push_item(OP_READ,  ADDR_RSV0,     16'h0000);
        push_item(OP_READ,  ADDR_RSV3,     16'h0000);
        push_item(OP_READ,  ADDR_REBOOT,   16'hFFFF);
        push_item(OP_READ,  ADDR_BOOT,     16'h0000);
        push_item(OP_READ,  ADDR_SERVICE,  16'h0000);
        push_item(OP_WRITE, ADDR_RELAY,    16'hFFFF);
        push_item(OP_WRITE, ADDR_RELAY,    16'h8000);
        push_item(OP_WRITE, ADDR_RELAY,    16'h7FFF);
        push_item(OP_WRITE, ADDR_SERVICE,  16'h8000);
        push_item(OP_WRITE, 16'hFFFF,      16'h5A5A);
        push_item(OP_WRITE, ADDR_ZERO,     16'h7FFF);
        push_item(OP_WRITE, ADDR_RSV1,     16'hA5A5);
        push_item(OP_WRITE, ADDR_BOOT,     16'h0000);
        push_item(OP_UNUSED, 16'hFFFF,     16'hFFFF);
        push_item(OP_UNUSED, 16'h0000,     16'h0000);
        push_item(OP_TICK,  16'hFFFF,      16'h8000);
        push_item(OP_TICK,  16'h0000,      16'h7FFF);
        push_item(OP_WRITE, ADDR_SERVICE,  RST_SERVICE_KEY);
        push_item(OP_READ,  ADDR_SERVICE,  16'h0000);

        // Receiver is stalled more often than the sender idles.
        start_phase(16'd12, 16'd3, 16'd4, 16'd5, RST_SERVICE_KEY, 17, 68);
        add_random(220);
        // Zero periods run both tasks on every tick; a zero timeout drops the link each time.
        start_phase(16'd0, 16'd0, 16'd0, 16'd0, 16'h8000, 17, 68);
        add_random(220);
        start_phase(16'd1, 16'd1, 16'd1, 16'hFFFF, 16'h7FFF, 17, 68);
        add_random(220);

        // Sender idles more often than the receiver stalls.
        start_phase(CFG_W'($urandom_range(40, 1)), CFG_W'($urandom_range(10)),
                    CFG_W'($urandom_range(10)), CFG_W'($urandom_range(20)),
                    CFG_W'($urandom), 68, 17);
        add_random(220);
        start_phase(16'hFFFF, 16'd2, 16'd3, 16'd1, 16'h0000, 68, 17);
        add_random(220);
        start_phase(16'd5, 16'd7, 16'd2, 16'd3, 16'hFFFF, 68, 17);
        add_random(220);

        // Neither side idles.
        start_phase(CFG_W'($urandom_range(40, 1)), CFG_W'($urandom_range(10)),
                    CFG_W'($urandom_range(10)), CFG_W'($urandom_range(20)),
                    CFG_W'($urandom), 0, 0);
        add_random(220);
        start_phase(16'd20, 16'd1, 16'hFFFF, 16'd0, 16'h1234, 0, 0);
        add_random(220);

        // Largest settings: neither task fires within this phase, the link stays up, and the
        // boot jump armed with the largest delay stays pending.
        start_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, CFG_W'($urandom), 0, 0);
        push_item(OP_WRITE, ADDR_RELAY, VALUE_W'($urandom));
        push_item(OP_WRITE, ADDR_BOOT, VALUE_W'($urandom));
        push_ticks(100);
        push_item(OP_READ, ADDR_BOOT, VALUE_W'($urandom));
        push_item(OP_READ, ADDR_RELAY_RB, VALUE_W'($urandom));
        push_item(OP_READ, ADDR_RELAY, VALUE_W'($urandom));
        push_ticks(3);

        // Last phase: ordinary traffic, then a reboot request. The next apply run freezes the
        // block, after which every kind of word must leave the status unchanged.
        start_phase(16'd6, 16'd3, 16'd2, 16'd2, RST_SERVICE_KEY, 0, 0);
        add_random(150);
        push_item(OP_WRITE, ADDR_RELAY, VALUE_W'($urandom));
        push_item(OP_WRITE, ADDR_REBOOT, VALUE_W'($urandom));
        push_item(OP_READ, ADDR_REBOOT, VALUE_W'($urandom));
        push_ticks(8);
        push_item(OP_READ, ADDR_RELAY_RB, VALUE_W'($urandom));
        push_item(OP_READ, 16'hFFFF, VALUE_W'($urandom));
        push_item(OP_WRITE, ADDR_RELAY, 16'hFFFF);
        push_item(OP_WRITE, ADDR_SERVICE, RST_SERVICE_KEY);
        push_item(OP_WRITE, ADDR_BOOT, VALUE_W'($urandom));
        push_item(OP_UNUSED, ADDR_W'($urandom), VALUE_W'($urandom));
        push_ticks(12);
        push_item(OP_READ, ADDR_REBOOT, VALUE_W'($urandom));

        wait_drained();
        repeat (8) @(posedge i_clk);
        $display("Run covered %0d accepted items and %0d checked status words over %0d settings.",
                 items_sent, words_checked, settings_used);
        $display("Link losses seen: %0d, boot jumps fired: %0d, frozen by reboot at the end: %0d.",
                 losses_seen, jumps_seen, frozen_q);
        if (fail_count == 0 && status_expected.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

FILE: filelist.f
sv/rrb_pkg.sv
sv/rrb_regmap.sv
sv/relay_register_block_link_timeout_core.sv
bench/testbench.sv
